// ===== sv/touch_press_debounce_tracker_assert.svh =====
// Assertion macros shared by the touch tracker RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef TOUCH_PRESS_DEBOUNCE_TRACKER_ASSERT_SVH
`define TOUCH_PRESS_DEBOUNCE_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TPDT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpdt assertion failed");
// next-cycle implication
`define TPDT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpdt assertion failed");
`else
`define TPDT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TPDT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/tpdt_pkg.sv =====
// Shared types and constants of the touch press debounce tracker.
// No dependencies; used by tpdt_csr, tpdt_div, the top level and the testbench.
`default_nettype none

package tpdt_pkg;

   localparam int EL_W     = 10;
   localparam int PR_W     = 10;
   localparam int RAW_W    = 11;
   localparam int SPAN_W   = 12;
   localparam int COORD_W  = 16;
   localparam int MS_W     = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // divider operand widths: |(s - lo) * span| < 2^24, |hi - lo| < 2^11
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 11;

   localparam logic [2:0] REG_PRESS_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_DEBOUNCE_MS     = 3'd1;
   localparam logic [2:0] REG_X_RAW_MIN       = 3'd2;
   localparam logic [2:0] REG_X_RAW_MAX       = 3'd3;
   localparam logic [2:0] REG_Y_RAW_MIN       = 3'd4;
   localparam logic [2:0] REG_Y_RAW_MAX       = 3'd5;
   localparam logic [2:0] REG_DISP_WIDTH      = 3'd6;
   localparam logic [2:0] REG_DISP_HEIGHT     = 3'd7;

   localparam logic [PR_W-1:0]   RST_PRESS_THRESHOLD = 10'd512;
   localparam logic [EL_W-1:0]   RST_DEBOUNCE_MS     = 10'd20;
   localparam logic [RAW_W-1:0]  RST_RAW_MIN         = 11'd0;
   localparam logic [RAW_W-1:0]  RST_RAW_MAX         = 11'd2046;
   localparam logic [SPAN_W-1:0] RST_DISP_WIDTH      = 12'd320;
   localparam logic [SPAN_W-1:0] RST_DISP_HEIGHT     = 12'd240;

   typedef struct packed {
      logic [PR_W-1:0]   press_threshold;
      logic [EL_W-1:0]   debounce_ms;
      logic [RAW_W-1:0]  x_raw_min;
      logic [RAW_W-1:0]  x_raw_max;
      logic [RAW_W-1:0]  y_raw_min;
      logic [RAW_W-1:0]  y_raw_max;
      logic [SPAN_W-1:0] disp_width;
      logic [SPAN_W-1:0] disp_height;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_START_X,
      ST_WAIT_X,
      ST_MUL_Y,
      ST_START_Y,
      ST_WAIT_Y,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== sv/touch_press_debounce_tracker.sv =====
// Touch press debounce tracker.
// Each req_ transaction is one panel poll (elapsed ms, pressure sample, X/Y
// electrode sums). Each poll yields exactly one rsp_ transaction with the raw
// and debounced touch state, press/release edge flags, the current, press-down
// and lift-off points, and saturating ms counters since press and release.
// Handshake: a transaction moves at a clock edge where valid is high and
// stall is low on that channel.
// Both coordinates of an accepted poll go through one 12x13 multiplier and
// one shared restoring divider (24 quotient bits, one per cycle), X first,
// then Y. req_stall is high from acceptance until the result is committed
// to the output register, so a new poll is not taken while one is in flight.
// If the receiver stalls, the finished result waits in the sequencer and the
// tracking state is committed only once the output register is free.
// Reset (synchronous, active high) restores the register defaults, clears the
// timers and flags, and sets the current point to -1,-1.
// Configuration registers sit at byte address 4*index; write them only while
// no poll is in flight.
// Depends on tpdt_pkg, tpdt_csr, tpdt_div and the assertion macro header.
`default_nettype none

`include "touch_press_debounce_tracker_assert.svh"

module touch_press_debounce_tracker #(
   parameter int TIMER_BITS = 16,
   parameter int ADC_BITS   = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [tpdt_pkg::EL_W-1:0]            req_elapsed_ms,
   input  wire logic [tpdt_pkg::PR_W-1:0]            req_pressure_sample,
   input  wire logic [tpdt_pkg::RAW_W-1:0]           req_x_pair_sum,
   input  wire logic [tpdt_pkg::RAW_W-1:0]           req_y_pair_sum,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_raw_touch,
   output logic                                      rsp_touch_held,
   output logic                                      rsp_press_edge,
   output logic                                      rsp_release_edge,
   output logic signed [tpdt_pkg::COORD_W-1:0]       rsp_pos_x,
   output logic signed [tpdt_pkg::COORD_W-1:0]       rsp_pos_y,
   output logic signed [tpdt_pkg::COORD_W-1:0]       rsp_press_x,
   output logic signed [tpdt_pkg::COORD_W-1:0]       rsp_press_y,
   output logic signed [tpdt_pkg::COORD_W-1:0]       rsp_lift_x,
   output logic signed [tpdt_pkg::COORD_W-1:0]       rsp_lift_y,
   output logic        [tpdt_pkg::MS_W-1:0]          rsp_ms_since_press,
   output logic        [tpdt_pkg::MS_W-1:0]          rsp_ms_since_release,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [tpdt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [tpdt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [tpdt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready
);

   localparam int EL_W    = tpdt_pkg::EL_W;
   localparam int PR_W    = tpdt_pkg::PR_W;
   localparam int RAW_W   = tpdt_pkg::RAW_W;
   localparam int SPAN_W  = tpdt_pkg::SPAN_W;
   localparam int CW      = tpdt_pkg::COORD_W;
   localparam int MS_W    = tpdt_pkg::MS_W;
   localparam int NUM_W   = tpdt_pkg::DIV_NUM_W;
   localparam int DEN_W   = tpdt_pkg::DIV_DEN_W;
   localparam int DIFF_W  = RAW_W + 1;
   localparam int PROD_W  = DIFF_W + SPAN_W + 1;
   localparam int SUM_W   = ((TIMER_BITS > EL_W) ? TIMER_BITS : EL_W) + 1;
   localparam int OUT_W   = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;
   localparam logic [SUM_W-1:0] TMAX_EXT = SUM_W'({TIMER_BITS{1'b1}});
   localparam logic [PR_W-1:0]  ADC_MASK = PR_W'((64'd1 << ADC_BITS) - 64'd1);

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------
   function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] t,
                                                     input logic [EL_W-1:0] d);
      logic [SUM_W-1:0] s;
      s = SUM_W'(t) + SUM_W'(d);
      if (s > TMAX_EXT) begin
         return {TIMER_BITS{1'b1}};
      end
      return s[TIMER_BITS-1:0];
   endfunction

   function automatic logic [MS_W-1:0] timer_out(input logic [TIMER_BITS-1:0] t);
      logic [OUT_W-1:0] e;
      e = OUT_W'(t);
      if (e > OUT_W'({MS_W{1'b1}})) begin
         return {MS_W{1'b1}};
      end
      return e[MS_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] ext_timer(input logic [TIMER_BITS-1:0] t);
      return SUM_W'(t);
   endfunction

   // clamp a signed quotient given as magnitude and sign to 16 bits
   function automatic logic [CW-1:0] sat_quot(input logic [NUM_W-1:0] mag,
                                               input logic neg);
      logic [NUM_W-1:0] negated;
      negated = ~mag + 1'b1;
      if (neg) begin
         if (mag >= NUM_W'(32768)) begin
            return {1'b1, {(CW-1){1'b0}}};
         end
         return negated[CW-1:0];
      end
      if (mag > NUM_W'(32767)) begin
         return {1'b0, {(CW-1){1'b1}}};
      end
      return mag[CW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // configuration and shared divider
   // ------------------------------------------------------------------
   tpdt_pkg::cfg_type        cfg;
   tpdt_pkg::div_status_type div_status;
   logic [NUM_W-1:0]         div_quotient;
   logic                     div_start;

   tpdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   tpdt_pkg::state_type state_ff, state_in;
   logic                accept;
   logic                out_free;
   logic                commit;
   logic                axis_y;
   logic                mul_en;
   logic                cap_x;
   logic                cap_y;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpdt_pkg::ST_IDLE:    if (req_valid) state_in = tpdt_pkg::ST_MUL_X;
         tpdt_pkg::ST_MUL_X:   state_in = tpdt_pkg::ST_START_X;
         tpdt_pkg::ST_START_X: state_in = tpdt_pkg::ST_WAIT_X;
         tpdt_pkg::ST_WAIT_X:  if (div_status.done) state_in = tpdt_pkg::ST_MUL_Y;
         tpdt_pkg::ST_MUL_Y:   state_in = tpdt_pkg::ST_START_Y;
         tpdt_pkg::ST_START_Y: state_in = tpdt_pkg::ST_WAIT_Y;
         tpdt_pkg::ST_WAIT_Y:  if (div_status.done) state_in = tpdt_pkg::ST_FINISH;
         tpdt_pkg::ST_FINISH:  if (out_free) state_in = tpdt_pkg::ST_IDLE;
         default:              state_in = tpdt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      axis_y    = 1'b0;
      mul_en    = 1'b0;
      div_start = 1'b0;
      cap_x     = 1'b0;
      cap_y     = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         tpdt_pkg::ST_IDLE:    req_stall = 1'b0;
         tpdt_pkg::ST_MUL_X:   mul_en = 1'b1;
         tpdt_pkg::ST_START_X: div_start = 1'b1;
         tpdt_pkg::ST_WAIT_X:  cap_x = div_status.done;
         tpdt_pkg::ST_MUL_Y: begin
            axis_y = 1'b1;
            mul_en = 1'b1;
         end
         tpdt_pkg::ST_START_Y: begin
            axis_y    = 1'b1;
            div_start = 1'b1;
         end
         tpdt_pkg::ST_WAIT_Y: begin
            axis_y = 1'b1;
            cap_y  = div_status.done;
         end
         tpdt_pkg::ST_FINISH:  commit = out_free;
         default:              req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpdt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // poll capture and coordinate scaling datapath
   // ------------------------------------------------------------------
   logic [EL_W-1:0]           el_ff;
   logic [PR_W-1:0]           pr_ff;
   logic [RAW_W-1:0]          xs_ff;
   logic [RAW_W-1:0]          ys_ff;
   logic [RAW_W-1:0]          sel_sum;
   logic [RAW_W-1:0]          sel_lo;
   logic [RAW_W-1:0]          sel_hi;
   logic [SPAN_W-1:0]         sel_span;
   logic signed [DIFF_W-1:0]  diff_s;
   logic signed [DIFF_W-1:0]  den_s;
   logic signed [SPAN_W:0]    span_s;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [NUM_W-1:0]          prod_mag;
   logic [DEN_W-1:0]          den_mag;
   logic                      quot_neg;
   logic [CW-1:0]             scaled;
   logic [CW-1:0]             scaled_x_ff;
   logic [CW-1:0]             scaled_y_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         el_ff <= req_elapsed_ms;
         pr_ff <= req_pressure_sample;
         xs_ff <= req_x_pair_sum;
         ys_ff <= req_y_pair_sum;
      end
   end

   assign sel_sum  = axis_y ? ys_ff : xs_ff;
   assign sel_lo   = axis_y ? cfg.y_raw_min : cfg.x_raw_min;
   assign sel_hi   = axis_y ? cfg.y_raw_max : cfg.x_raw_max;
   assign sel_span = axis_y ? cfg.disp_height : cfg.disp_width;

   assign diff_s = $signed({1'b0, sel_sum}) - $signed({1'b0, sel_lo});
   assign den_s  = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo});
   assign span_s = $signed({1'b0, sel_span});

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= diff_s * span_s;
      end
   end

   assign prod_mag = prod_ff[PROD_W-1] ? NUM_W'(-prod_ff) : prod_ff[NUM_W-1:0];
   assign den_mag  = den_s[DIFF_W-1] ? DEN_W'(-den_s) : den_s[DEN_W-1:0];
   assign quot_neg = prod_ff[PROD_W-1] ^ den_s[DIFF_W-1];
   // a zero input span maps to coordinate zero
   assign scaled   = (den_s == '0) ? '0 : sat_quot(div_quotient, quot_neg);

   tpdt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (prod_mag),
      .den      (den_mag),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (cap_x) begin
         scaled_x_ff <= scaled;
      end
      if (cap_y) begin
         scaled_y_ff <= scaled;
      end
   end

   // ------------------------------------------------------------------
   // debounce and tracking state
   // ------------------------------------------------------------------
   logic                  raw_prev_ff, raw_prev_in;
   logic                  held_flag_ff, held_flag_in;
   logic [TIMER_BITS-1:0] raw_down_ff, raw_down_in;
   logic [TIMER_BITS-1:0] raw_up_ff, raw_up_in;
   logic [TIMER_BITS-1:0] press_tmr_ff, press_tmr_in;
   logic [TIMER_BITS-1:0] release_tmr_ff, release_tmr_in;
   logic [CW-1:0]         cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]         held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [CW-1:0]         down_x_ff, down_x_in, down_y_ff, down_y_in;
   logic [CW-1:0]         up_x_ff, up_x_in, up_y_ff, up_y_in;
   logic                  raw;
   logic                  pedge;
   logic                  redge;

   assign raw = (pr_ff & ADC_MASK) < cfg.press_threshold;

   always_comb begin
      raw_down_in    = sat_add(raw_down_ff, el_ff);
      raw_up_in      = sat_add(raw_up_ff, el_ff);
      press_tmr_in   = sat_add(press_tmr_ff, el_ff);
      release_tmr_in = sat_add(release_tmr_ff, el_ff);
      held_flag_in   = held_flag_ff;
      up_x_in        = up_x_ff;
      up_y_in        = up_y_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      down_x_in      = down_x_ff;
      down_y_in      = down_y_ff;

      if (raw && !raw_prev_ff) begin
         raw_down_in = '0;
      end
      // raw lift: restart the up timer and keep the last held point
      if (!raw && raw_prev_ff) begin
         raw_up_in = '0;
         up_x_in   = held_x_ff;
         up_y_in   = held_y_ff;
      end
      if (raw && (ext_timer(raw_down_in) > SUM_W'(cfg.debounce_ms))) begin
         held_flag_in = 1'b1;
      end
      if (!raw && (ext_timer(raw_up_in) > SUM_W'(cfg.debounce_ms))) begin
         held_flag_in = 1'b0;
      end
      if (raw) begin
         cur_x_in = scaled_x_ff;
         cur_y_in = scaled_y_ff;
      end
      if (held_flag_in) begin
         held_x_in = cur_x_in;
         held_y_in = cur_y_in;
      end
      pedge = !held_flag_ff && held_flag_in;
      redge = held_flag_ff && !held_flag_in;
      if (pedge) begin
         down_x_in    = cur_x_in;
         down_y_in    = cur_y_in;
         press_tmr_in = '0;
      end
      if (redge) begin
         release_tmr_in = '0;
      end
      raw_prev_in = raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff    <= 1'b0;
         held_flag_ff   <= 1'b0;
         raw_down_ff    <= '0;
         raw_up_ff      <= '0;
         press_tmr_ff   <= '0;
         release_tmr_ff <= '0;
         cur_x_ff       <= '1;
         cur_y_ff       <= '1;
         held_x_ff      <= '0;
         held_y_ff      <= '0;
         down_x_ff      <= '0;
         down_y_ff      <= '0;
         up_x_ff        <= '0;
         up_y_ff        <= '0;
      end else if (commit) begin
         raw_prev_ff    <= raw_prev_in;
         held_flag_ff   <= held_flag_in;
         raw_down_ff    <= raw_down_in;
         raw_up_ff      <= raw_up_in;
         press_tmr_ff   <= press_tmr_in;
         release_tmr_ff <= release_tmr_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         held_x_ff      <= held_x_in;
         held_y_ff      <= held_y_in;
         down_x_ff      <= down_x_in;
         down_y_ff      <= down_y_in;
         up_x_ff        <= up_x_in;
         up_y_ff        <= up_y_in;
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_raw_touch        <= raw;
         rsp_touch_held       <= held_flag_in;
         rsp_press_edge       <= pedge;
         rsp_release_edge     <= redge;
         rsp_pos_x            <= cur_x_in;
         rsp_pos_y            <= cur_y_in;
         rsp_press_x          <= down_x_in;
         rsp_press_y          <= down_y_in;
         rsp_lift_x           <= up_x_in;
         rsp_lift_y           <= up_y_in;
         rsp_ms_since_press   <= timer_out(press_tmr_in);
         rsp_ms_since_release <= timer_out(release_tmr_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   logic press_ok;
   logic release_ok;

   assign press_ok   = rsp_touch_held && rsp_raw_touch && (rsp_ms_since_press == '0);
   assign release_ok = !rsp_touch_held && !rsp_raw_touch && (rsp_ms_since_release == '0);

   `TPDT_ASSERT_IMP(a_edges_exclusive, clock, reset, rsp_valid, !(rsp_press_edge && rsp_release_edge))
   `TPDT_ASSERT_IMP(a_press_held, clock, reset, rsp_valid && rsp_press_edge, press_ok)
   `TPDT_ASSERT_IMP(a_release_clear, clock, reset, rsp_valid && rsp_release_edge, release_ok)
   `TPDT_ASSERT_IMP(a_div_idle_commit, clock, reset, commit, !div_status.busy)

endmodule

`default_nettype wire

// ===== sv/tpdt_csr.sv =====
// Configuration register file with an APB-style write/read port.
// Depends on tpdt_pkg for the register map, reset values and cfg_type.
`default_nettype none

module tpdt_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [tpdt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [tpdt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [tpdt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output tpdt_pkg::cfg_type                        cfg
);

   tpdt_pkg::cfg_type cfg_ff;
   tpdt_pkg::cfg_type cfg_in;
   logic [2:0]        reg_index;
   logic              wr_en;

   assign reg_index  = csr_paddr[tpdt_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            tpdt_pkg::REG_PRESS_THRESHOLD:
               cfg_in.press_threshold = csr_pwdata[tpdt_pkg::PR_W-1:0];
            tpdt_pkg::REG_DEBOUNCE_MS:
               cfg_in.debounce_ms = csr_pwdata[tpdt_pkg::EL_W-1:0];
            tpdt_pkg::REG_X_RAW_MIN:
               cfg_in.x_raw_min = csr_pwdata[tpdt_pkg::RAW_W-1:0];
            tpdt_pkg::REG_X_RAW_MAX:
               cfg_in.x_raw_max = csr_pwdata[tpdt_pkg::RAW_W-1:0];
            tpdt_pkg::REG_Y_RAW_MIN:
               cfg_in.y_raw_min = csr_pwdata[tpdt_pkg::RAW_W-1:0];
            tpdt_pkg::REG_Y_RAW_MAX:
               cfg_in.y_raw_max = csr_pwdata[tpdt_pkg::RAW_W-1:0];
            tpdt_pkg::REG_DISP_WIDTH:
               cfg_in.disp_width = csr_pwdata[tpdt_pkg::SPAN_W-1:0];
            tpdt_pkg::REG_DISP_HEIGHT:
               cfg_in.disp_height = csr_pwdata[tpdt_pkg::SPAN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         tpdt_pkg::REG_PRESS_THRESHOLD:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.press_threshold);
         tpdt_pkg::REG_DEBOUNCE_MS:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.debounce_ms);
         tpdt_pkg::REG_X_RAW_MIN:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.x_raw_min);
         tpdt_pkg::REG_X_RAW_MAX:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.x_raw_max);
         tpdt_pkg::REG_Y_RAW_MIN:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.y_raw_min);
         tpdt_pkg::REG_Y_RAW_MAX:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.y_raw_max);
         tpdt_pkg::REG_DISP_WIDTH:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.disp_width);
         tpdt_pkg::REG_DISP_HEIGHT:
            csr_prdata = tpdt_pkg::CSR_DATA_W'(cfg_ff.disp_height);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold <= tpdt_pkg::RST_PRESS_THRESHOLD;
         cfg_ff.debounce_ms     <= tpdt_pkg::RST_DEBOUNCE_MS;
         cfg_ff.x_raw_min       <= tpdt_pkg::RST_RAW_MIN;
         cfg_ff.x_raw_max       <= tpdt_pkg::RST_RAW_MAX;
         cfg_ff.y_raw_min       <= tpdt_pkg::RST_RAW_MIN;
         cfg_ff.y_raw_max       <= tpdt_pkg::RST_RAW_MAX;
         cfg_ff.disp_width      <= tpdt_pkg::RST_DISP_WIDTH;
         cfg_ff.disp_height     <= tpdt_pkg::RST_DISP_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tpdt_div.sv =====
// Shared restoring divider on magnitudes, one quotient bit per cycle.
// Depends on tpdt_pkg for operand widths and the status struct.
`default_nettype none

`include "touch_press_debounce_tracker_assert.svh"

module tpdt_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [tpdt_pkg::DIV_NUM_W-1:0]    num,
   input  wire logic [tpdt_pkg::DIV_DEN_W-1:0]    den,
   output logic      [tpdt_pkg::DIV_NUM_W-1:0]    quotient,
   output tpdt_pkg::div_status_type               status
);

   localparam int NUM_W = tpdt_pkg::DIV_NUM_W;
   localparam int DEN_W = tpdt_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // shift the next dividend bit in, subtract when the divisor fits
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_sub   = rem_shift - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `TPDT_ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff)
   `TPDT_ASSERT_NXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   `TPDT_ASSERT_IMP(a_busy_count, clock, reset, busy_ff, cnt_ff != '0)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for touch_press_debounce_tracker: directed and random panel polls, checked
// against an in-bench tracking model, with APB register setup between phases.
// Depends on tpdt_pkg and the touch_press_debounce_tracker RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EL_W       = tpdt_pkg::EL_W;
   localparam int PR_W       = tpdt_pkg::PR_W;
   localparam int RAW_W      = tpdt_pkg::RAW_W;
   localparam int SPAN_W     = tpdt_pkg::SPAN_W;
   localparam int COORD_W    = tpdt_pkg::COORD_W;
   localparam int MS_W       = tpdt_pkg::MS_W;
   localparam int CSR_ADDR_W = tpdt_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = tpdt_pkg::CSR_DATA_W;

   typedef struct packed {
      logic [EL_W-1:0]  elapsed_ms;
      logic [PR_W-1:0]  pressure_sample;
      logic [RAW_W-1:0] x_pair_sum;
      logic [RAW_W-1:0] y_pair_sum;
   } poll_type;

   typedef struct packed {
      logic                      raw_touch;
      logic                      touch_held;
      logic                      press_edge;
      logic                      release_edge;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] press_x;
      logic signed [COORD_W-1:0] press_y;
      logic signed [COORD_W-1:0] lift_x;
      logic signed [COORD_W-1:0] lift_y;
      logic [MS_W-1:0]           ms_since_press;
      logic [MS_W-1:0]           ms_since_release;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [EL_W-1:0]           req_elapsed_ms = '0;
   logic [PR_W-1:0]           req_pressure_sample = '0;
   logic [RAW_W-1:0]          req_x_pair_sum = '0;
   logic [RAW_W-1:0]          req_y_pair_sum = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_raw_touch;
   logic                      rsp_touch_held;
   logic                      rsp_press_edge;
   logic                      rsp_release_edge;
   logic signed [COORD_W-1:0] rsp_pos_x;
   logic signed [COORD_W-1:0] rsp_pos_y;
   logic signed [COORD_W-1:0] rsp_press_x;
   logic signed [COORD_W-1:0] rsp_press_y;
   logic signed [COORD_W-1:0] rsp_lift_x;
   logic signed [COORD_W-1:0] rsp_lift_y;
   logic [MS_W-1:0]           rsp_ms_since_press;
   logic [MS_W-1:0]           rsp_ms_since_release;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   touch_press_debounce_tracker dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tracking model: configuration and state
   tpdt_pkg::cfg_type   panel_cfg;
   logic                prev_touch, debounced;
   logic [MS_W-1:0]     touch_age, lift_age, press_age, release_age;
   logic signed [15:0]  now_x, now_y, track_x, track_y, grab_x, grab_y, drop_x, drop_y;

   poll_type            poll_q[$];
   report_type          report_q[$];
   poll_type            next_poll, seen_poll;
   report_type          want;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  fail_count = 0;

   function automatic logic [MS_W-1:0] sat_ms(logic [MS_W-1:0] t, logic [EL_W-1:0] d);
      logic [MS_W:0] s;
      s = t + d;
      return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
   endfunction

   // linear map, truncating toward zero, saturated to 16 bits signed
   function automatic logic signed [15:0] map_coord(logic [RAW_W-1:0] s, logic [RAW_W-1:0] lo,
                                                    logic [RAW_W-1:0] hi, logic [SPAN_W-1:0] span);
      int span_in, q;
      span_in = int'(hi) - int'(lo);
      if (span_in == 0)
         return '0;
      q = ((int'(s) - int'(lo)) * int'(span)) / span_in;
      if (q > 32767)
         q = 32767;
      if (q < -32768)
         q = -32768;
      return q[15:0];
   endfunction

   function automatic report_type track_poll(poll_type p);
      report_type r;
      logic was_held, raw;
      was_held = debounced;
      touch_age = sat_ms(touch_age, p.elapsed_ms);
      lift_age = sat_ms(lift_age, p.elapsed_ms);
      press_age = sat_ms(press_age, p.elapsed_ms);
      release_age = sat_ms(release_age, p.elapsed_ms);
      raw = p.pressure_sample < panel_cfg.press_threshold;
      if (raw && !prev_touch)
         touch_age = '0;
      if (!raw && prev_touch) begin
         lift_age = '0;
         drop_x = track_x;
         drop_y = track_y;
      end
      if (raw && touch_age > panel_cfg.debounce_ms)
         debounced = 1'b1;
      if (!raw && lift_age > panel_cfg.debounce_ms)
         debounced = 1'b0;
      if (raw) begin
         now_x = map_coord(p.x_pair_sum, panel_cfg.x_raw_min, panel_cfg.x_raw_max,
                           panel_cfg.disp_width);
         now_y = map_coord(p.y_pair_sum, panel_cfg.y_raw_min, panel_cfg.y_raw_max,
                           panel_cfg.disp_height);
      end
      if (debounced) begin
         track_x = now_x;
         track_y = now_y;
      end
      r.press_edge = !was_held && debounced;
      if (r.press_edge) begin
         grab_x = now_x;
         grab_y = now_y;
         press_age = '0;
      end
      r.release_edge = was_held && !debounced;
      if (r.release_edge)
         release_age = '0;
      prev_touch = raw;
      r.raw_touch = raw;
      r.touch_held = debounced;
      r.pos_x = now_x;
      r.pos_y = now_y;
      r.press_x = grab_x;
      r.press_y = grab_y;
      r.lift_x = drop_x;
      r.lift_y = drop_y;
      r.ms_since_press = press_age;
      r.ms_since_release = release_age;
      return r;
   endfunction

   task automatic check_field(string name, logic signed [31:0] want_v,
                              logic signed [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   task automatic write_panel_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         tpdt_pkg::REG_PRESS_THRESHOLD: panel_cfg.press_threshold = data[PR_W-1:0];
         tpdt_pkg::REG_DEBOUNCE_MS:     panel_cfg.debounce_ms = data[EL_W-1:0];
         tpdt_pkg::REG_X_RAW_MIN:       panel_cfg.x_raw_min = data[RAW_W-1:0];
         tpdt_pkg::REG_X_RAW_MAX:       panel_cfg.x_raw_max = data[RAW_W-1:0];
         tpdt_pkg::REG_Y_RAW_MIN:       panel_cfg.y_raw_min = data[RAW_W-1:0];
         tpdt_pkg::REG_Y_RAW_MAX:       panel_cfg.y_raw_max = data[RAW_W-1:0];
         tpdt_pkg::REG_DISP_WIDTH:      panel_cfg.disp_width = data[SPAN_W-1:0];
         tpdt_pkg::REG_DISP_HEIGHT:     panel_cfg.disp_height = data[SPAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic add_poll(int el, int pr, int xs, int ys);
      poll_type p;
      p.elapsed_ms = EL_W'(el);
      p.pressure_sample = PR_W'(pr);
      p.x_pair_sum = RAW_W'(xs);
      p.y_pair_sum = RAW_W'(ys);
      poll_q.push_back(p);
   endtask

   // hold until every poll is sent and every report has come back
   task automatic wait_drained();
      while (poll_q.size() != 0 || req_valid || report_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one axis range: mostly normal, sometimes zero or inverted span or extremes
   task automatic write_axis(logic [2:0] min_idx, logic [2:0] max_idx);
      int lo, hi;
      case ($urandom_range(9))
         0: begin
            lo = $urandom_range(2047);
            hi = lo;
         end
         1: begin
            lo = $urandom_range(1200, 2047);
            hi = $urandom_range(0, 800);
         end
         2: begin
            lo = 0;
            hi = $urandom_range(1) ? 2047 : 2046;
         end
         3: begin
            lo = $urandom_range(2046);
            hi = lo + 1;
         end
         default: begin
            lo = $urandom_range(0, 800);
            hi = $urandom_range(1200, 2047);
         end
      endcase
      write_panel_reg(min_idx, ($urandom() << RAW_W) | lo);
      write_panel_reg(max_idx, ($urandom() << RAW_W) | hi);
   endtask

   task automatic randomize_panel_cfg();
      int thr, deb, w, h;
      case ($urandom_range(9))
         0: thr = 0;
         1: thr = 1023;
         default: thr = $urandom_range(100, 900);
      endcase
      case ($urandom_range(9))
         0: deb = 0;
         1: deb = 1023;
         default: deb = $urandom_range(1, 60);
      endcase
      w = ($urandom_range(9) == 0) ? 0
          : (($urandom_range(9) == 0) ? 4095 : $urandom_range(1, 4095));
      h = ($urandom_range(9) == 0) ? 0
          : (($urandom_range(9) == 0) ? 4095 : $urandom_range(1, 4095));
      write_panel_reg(tpdt_pkg::REG_PRESS_THRESHOLD, ($urandom() << PR_W) | thr);
      write_panel_reg(tpdt_pkg::REG_DEBOUNCE_MS, ($urandom() << EL_W) | deb);
      write_axis(tpdt_pkg::REG_X_RAW_MIN, tpdt_pkg::REG_X_RAW_MAX);
      write_axis(tpdt_pkg::REG_Y_RAW_MIN, tpdt_pkg::REG_Y_RAW_MAX);
      write_panel_reg(tpdt_pkg::REG_DISP_WIDTH, ($urandom() << SPAN_W) | w);
      write_panel_reg(tpdt_pkg::REG_DISP_HEIGHT, ($urandom() << SPAN_W) | h);
   endtask

   // alternate press and lift runs; some bounce noise, some long holds or idles
   task automatic queue_touch_gestures(int n);
      int left, run, k, thr;
      bit pressing, long_run;
      poll_type p;
      left = n;
      pressing = $urandom_range(1);
      thr = panel_cfg.press_threshold;
      while (left > 0) begin
         long_run = ($urandom_range(19) == 0);
         run = long_run ? $urandom_range(66, 90) : $urandom_range(1, 12);
         for (k = 0; k < run && left > 0; k++) begin
            if (long_run)
               p.elapsed_ms = EL_W'(1023 - $urandom_range(3));
            else if ($urandom_range(9) == 0)
               p.elapsed_ms = EL_W'($urandom_range(1023));
            else
               p.elapsed_ms = EL_W'($urandom_range(0, int'(panel_cfg.debounce_ms) / 4 + 4));
            if (!long_run && $urandom_range(99) < 15)
               p.pressure_sample = PR_W'($urandom_range(1023));
            else if (pressing)
               p.pressure_sample = PR_W'((thr == 0) ? $urandom_range(1023)
                                                    : $urandom_range(0, thr - 1));
            else
               p.pressure_sample = PR_W'($urandom_range(thr, 1023));
            p.x_pair_sum = RAW_W'($urandom_range(2047));
            p.y_pair_sum = RAW_W'($urandom_range(2047));
            poll_q.push_back(p);
            left--;
         end
         pressing = !pressing;
      end
   endtask

   // driver: predict on acceptance, then present the next poll
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            seen_poll.elapsed_ms = req_elapsed_ms;
            seen_poll.pressure_sample = req_pressure_sample;
            seen_poll.x_pair_sum = req_x_pair_sum;
            seen_poll.y_pair_sum = req_y_pair_sum;
            report_q.push_back(track_poll(seen_poll));
         end
         if (!req_valid || !req_stall) begin
            if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_poll = poll_q.pop_front();
               req_valid <= 1'b1;
               req_elapsed_ms <= next_poll.elapsed_ms;
               req_pressure_sample <= next_poll.pressure_sample;
               req_x_pair_sum <= next_poll.x_pair_sum;
               req_y_pair_sum <= next_poll.y_pair_sum;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: compare each accepted transaction with the oldest expected report
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (report_q.size() == 0) begin
            $display("%0t: report with none expected", $time);
            fail_count++;
         end else begin
            want = report_q.pop_front();
            check_field("raw_touch", want.raw_touch, rsp_raw_touch);
            check_field("touch_held", want.touch_held, rsp_touch_held);
            check_field("press_edge", want.press_edge, rsp_press_edge);
            check_field("release_edge", want.release_edge, rsp_release_edge);
            check_field("pos_x", want.pos_x, rsp_pos_x);
            check_field("pos_y", want.pos_y, rsp_pos_y);
            check_field("press_x", want.press_x, rsp_press_x);
            check_field("press_y", want.press_y, rsp_press_y);
            check_field("lift_x", want.lift_x, rsp_lift_x);
            check_field("lift_y", want.lift_y, rsp_lift_y);
            check_field("ms_since_press", want.ms_since_press, rsp_ms_since_press);
            check_field("ms_since_release", want.ms_since_release, rsp_ms_since_release);
         end
      end
   end

   initial begin
      panel_cfg.press_threshold = tpdt_pkg::RST_PRESS_THRESHOLD;
      panel_cfg.debounce_ms = tpdt_pkg::RST_DEBOUNCE_MS;
      panel_cfg.x_raw_min = tpdt_pkg::RST_RAW_MIN;
      panel_cfg.x_raw_max = tpdt_pkg::RST_RAW_MAX;
      panel_cfg.y_raw_min = tpdt_pkg::RST_RAW_MIN;
      panel_cfg.y_raw_max = tpdt_pkg::RST_RAW_MAX;
      panel_cfg.disp_width = tpdt_pkg::RST_DISP_WIDTH;
      panel_cfg.disp_height = tpdt_pkg::RST_DISP_HEIGHT;
      prev_touch = 1'b0;
      debounced = 1'b0;
      touch_age = '0;
      lift_age = '0;
      press_age = '0;
      release_age = '0;
      now_x = -16'sd1;
      now_y = -16'sd1;
      {track_x, track_y, grab_x, grab_y, drop_x, drop_y} = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 10;
      recv_idle_pct = 65;

      // defaults: idle position, out-of-range sums, debounce boundary, release
      add_poll(0, 1023, 0, 0);
      add_poll(1023, 511, 2047, 2047);
      add_poll(0, 0, 0, 0);
      add_poll(21, 0, 1023, 1023);
      add_poll(1023, 512, 100, 100);
      add_poll(20, 1023, 0, 0);
      add_poll(1, 700, 2046, 2046);
      add_poll(1023, 1023, 2046, 2046);
      wait_drained();

      // coordinate saturation both ways, zero debounce, top threshold
      write_panel_reg(tpdt_pkg::REG_PRESS_THRESHOLD, 1023);
      write_panel_reg(tpdt_pkg::REG_DEBOUNCE_MS, 0);
      write_panel_reg(tpdt_pkg::REG_X_RAW_MIN, 0);
      write_panel_reg(tpdt_pkg::REG_X_RAW_MAX, 1);
      write_panel_reg(tpdt_pkg::REG_Y_RAW_MIN, 2046);
      write_panel_reg(tpdt_pkg::REG_Y_RAW_MAX, 2047);
      write_panel_reg(tpdt_pkg::REG_DISP_WIDTH, 4095);
      write_panel_reg(tpdt_pkg::REG_DISP_HEIGHT, 4095);
      add_poll(0, 1022, 2047, 0);
      add_poll(1, 1022, 1, 2047);
      add_poll(0, 1023, 0, 0);
      add_poll(5, 1023, 0, 0);
      add_poll(0, 0, 0, 2046);
      wait_drained();

      // zero X span, inverted Y span, zero width, longest debounce
      write_panel_reg(tpdt_pkg::REG_PRESS_THRESHOLD, 300);
      write_panel_reg(tpdt_pkg::REG_DEBOUNCE_MS, 1023);
      write_panel_reg(tpdt_pkg::REG_X_RAW_MIN, 1000);
      write_panel_reg(tpdt_pkg::REG_X_RAW_MAX, 1000);
      write_panel_reg(tpdt_pkg::REG_Y_RAW_MIN, 2046);
      write_panel_reg(tpdt_pkg::REG_Y_RAW_MAX, 0);
      write_panel_reg(tpdt_pkg::REG_DISP_WIDTH, 0);
      write_panel_reg(tpdt_pkg::REG_DISP_HEIGHT, 240);
      add_poll(0, 0, 1000, 0);
      add_poll(1023, 299, 2047, 2046);
      add_poll(1, 100, 5, 1023);
      add_poll(0, 300, 0, 0);
      add_poll(1023, 1023, 0, 0);
      add_poll(1, 1023, 0, 0);
      wait_drained();

      for (int phase = 0; phase < 9; phase++) begin
         send_idle_pct = (phase < 3) ? 10 : ((phase < 6) ? 65 : 0);
         recv_idle_pct = (phase < 3) ? 65 : ((phase < 6) ? 10 : 0);
         randomize_panel_cfg();
         queue_touch_gestures(100);
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tpdt_pkg.sv
sv/tpdt_csr.sv
sv/tpdt_div.sv
sv/touch_press_debounce_tracker.sv
dv/tb.sv
